### hw/rtl/ps2_mouse_packet_tracker_defines.svh
// Assertion macros shared by the PS/2 mouse packet tracker RTL.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Property checked on every rising aclk edge outside of reset.
`define PS2MT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define PS2MT_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

### hw/rtl/ps2mt_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse packet tracker.
package ps2mt_pkg;

    // Bit positions inside the flags byte (first byte of a packet)
    localparam int ALWAYS_ONE_IDX = 3;
    localparam int X_SIGN_IDX     = 4;
    localparam int Y_SIGN_IDX     = 5;
    localparam int X_OVF_IDX      = 6;
    localparam int Y_OVF_IDX      = 7;
    localparam int BUTTON_W       = 3;

    // Wheel byte: sign-magnitude, magnitude in the low bits
    localparam int Z_MAG_W        = 3;
    localparam int Z_SIGN_IDX     = 3;

    // Motion used when a packet flags an axis overflow
    localparam logic signed [9:0] OVF_POS_DELTA = 10'sd127;
    localparam logic signed [9:0] OVF_NEG_DELTA = -10'sd128;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FOUR_BYTE_PACKETS = 1'b0,
        CFG_WHEEL_ENABLED     = 1'b1
    } cfg_index_t;

    // Position of the next byte inside a packet
    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_X     = 2'd1,
        POS_Y     = 2'd2,
        POS_Z     = 2'd3
    } byte_pos_t;

    // Completed packet handed from the assembler to the accumulator
    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] x_data;
        logic [7:0] y_data;
        logic [7:0] z_data;
        logic       have_z;
    } ps2mt_packet_t;

    // Signed motion of one axis from its data byte and flag bits
    function automatic logic signed [9:0] axis_delta(
        input logic       sign_bit,
        input logic       ovf_bit,
        input logic       invert,
        input logic [7:0] data
    );
        logic signed [9:0] d;
        d = $signed({sign_bit, sign_bit, data});
        if (ovf_bit) begin
            return sign_bit ? OVF_NEG_DELTA : OVF_POS_DELTA;
        end
        return invert ? -d : d;
    endfunction

endpackage

### hw/rtl/ps2mt_assembler.sv
// Gathers received bytes into 3- or 4-byte mouse packets.
module ps2mt_assembler (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    input  logic                    four_byte_packets,
    input  logic                    wheel_enabled,
    output logic                    pkt_valid,
    input  logic                    pkt_ready,
    output ps2mt_pkg::ps2mt_packet_t pkt
);
    import ps2mt_pkg::*;

    byte_pos_t     pos_reg, pos_next;
    logic [7:0]    bytes_reg [3];
    logic          store_en;
    logic          accept;
    byte_pos_t     last_pos;
    logic          pkt_valid_reg, pkt_valid_next;
    ps2mt_packet_t pkt_reg, pkt_next;

    assign s_ready  = !pkt_valid_reg || pkt_ready;
    assign accept   = s_valid && s_ready;
    assign last_pos = four_byte_packets ? POS_Z : POS_Y;

    // Sequence the bytes of a packet; emit it on the last byte
    always_comb begin
        pos_next       = pos_reg;
        store_en       = 1'b0;
        pkt_valid_next = pkt_valid_reg && !pkt_ready;
        pkt_next       = pkt_reg;
        if (accept) begin
            if (pos_reg == POS_FLAGS && !s_rx_byte[ALWAYS_ONE_IDX]) begin
                // out of sync: drop until a plausible flags byte
                pos_next = POS_FLAGS;
            end else if (pos_reg < last_pos) begin
                store_en = 1'b1;
                pos_next = byte_pos_t'(pos_reg + 2'd1);
            end else begin
                pkt_valid_next  = 1'b1;
                pkt_next.flags  = bytes_reg[0];
                pkt_next.x_data = bytes_reg[1];
                pkt_next.y_data = (pos_reg == POS_Y) ? s_rx_byte : bytes_reg[2];
                pkt_next.z_data = s_rx_byte;
                pkt_next.have_z = (pos_reg == POS_Z) && four_byte_packets && wheel_enabled;
                pos_next        = POS_FLAGS;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FLAGS;
            pkt_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    // Packet byte store and packet register (payload, no reset)
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (store_en && pos_reg == byte_pos_t'(i)) begin
                bytes_reg[i] <= s_rx_byte;
            end
        end
        pkt_reg <= pkt_next;
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

### hw/rtl/ps2mt_accumulator.sv
// Applies a completed packet to the button state and X/Y/Z positions.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_accumulator #(
    parameter int POS_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pkt_valid,
    output logic                        pkt_ready,
    input  ps2mt_pkg::ps2mt_packet_t    pkt,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [POS_WIDTH-1:0]        m_x_position,
    output logic [POS_WIDTH-1:0]        m_y_position,
    output logic signed [POS_WIDTH-1:0] m_z_position,
    output logic [ps2mt_pkg::BUTTON_W-1:0] m_button_bits
);
    import ps2mt_pkg::*;

    localparam int SUM_W = POS_WIDTH + 2;

    logic                        load;
    logic                        m_valid_reg, m_valid_next;
    logic [POS_WIDTH-1:0]        x_accum_reg, x_accum_next;
    logic [POS_WIDTH-1:0]        y_accum_reg, y_accum_next;
    logic signed [POS_WIDTH-1:0] z_accum_reg, z_accum_next;
    logic [BUTTON_W-1:0]         buttons_reg;
    logic signed [9:0]           x_delta, y_delta;
    logic signed [3:0]           z_delta;
    logic signed [SUM_W-1:0]     x_sum, y_sum;
    logic signed [POS_WIDTH:0]   z_sum;

    assign pkt_ready    = !m_valid_reg || m_ready;
    assign load         = pkt_valid && pkt_ready;
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    // Per-axis motion
    always_comb begin
        x_delta = axis_delta(pkt.flags[X_SIGN_IDX], pkt.flags[X_OVF_IDX], 1'b0, pkt.x_data);
        y_delta = axis_delta(pkt.flags[Y_SIGN_IDX], pkt.flags[Y_OVF_IDX], 1'b1, pkt.y_data);
        z_delta = pkt.z_data[Z_SIGN_IDX] ? -$signed({1'b0, pkt.z_data[Z_MAG_W-1:0]})
                                         :  $signed({1'b0, pkt.z_data[Z_MAG_W-1:0]});
    end

    // X/Y: clamp at zero, saturate at all ones
    always_comb begin
        x_sum = $signed({2'b00, x_accum_reg}) + SUM_W'(x_delta);
        y_sum = $signed({2'b00, y_accum_reg}) + SUM_W'(y_delta);
        if (x_sum[SUM_W-1]) begin
            x_accum_next = '0;
        end else if (x_sum[SUM_W-2]) begin
            x_accum_next = '1;
        end else begin
            x_accum_next = x_sum[POS_WIDTH-1:0];
        end
        if (y_sum[SUM_W-1]) begin
            y_accum_next = '0;
        end else if (y_sum[SUM_W-2]) begin
            y_accum_next = '1;
        end else begin
            y_accum_next = y_sum[POS_WIDTH-1:0];
        end
    end

    // Z: signed saturation both ways, only with wheel data
    always_comb begin
        z_sum = $signed({z_accum_reg[POS_WIDTH-1], z_accum_reg}) + (POS_WIDTH+1)'(z_delta);
        if (!pkt.have_z) begin
            z_accum_next = z_accum_reg;
        end else if (z_sum[POS_WIDTH] != z_sum[POS_WIDTH-1]) begin
            z_accum_next = z_sum[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                                            : {1'b0, {(POS_WIDTH-1){1'b1}}};
        end else begin
            z_accum_next = z_sum[POS_WIDTH-1:0];
        end
    end

    // Accumulators double as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            x_accum_reg <= '0;
            y_accum_reg <= '0;
            z_accum_reg <= '0;
            buttons_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                x_accum_reg <= x_accum_next;
                y_accum_reg <= y_accum_next;
                z_accum_reg <= z_accum_next;
                buttons_reg <= pkt.flags[BUTTON_W-1:0];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_x_position  = x_accum_reg;
    assign m_y_position  = y_accum_reg;
    assign m_z_position  = z_accum_reg;
    assign m_button_bits = buttons_reg;

    `PS2MT_ASSERT(a_load_gives_result, (pkt_valid && pkt_ready) |=> m_valid, "packet lost")
    `PS2MT_ASSERT_NEVER(a_empty_output_stalls, !m_valid_reg && !pkt_ready, "empty slot stalled")
    `PS2MT_ASSERT(a_position_held, !(pkt_valid && pkt_ready) |=> ($stable(x_accum_reg) && $stable(y_accum_reg) && $stable(z_accum_reg)), "position moved without packet")

endmodule

### hw/rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
// Takes one received byte per cycle; a request is accepted every cycle unless the output stalls.
// After its last byte is accepted, the result of a packet passes through the packet register,
// then the accumulator/result register, before it is valid.
// Throughput: one byte per cycle unless the output stalls, one result per completed packet (3 or 4 bytes).
// Reset (aresetn low, synchronous): positions, buttons, byte position and config clear.
module ps2_mouse_packet_tracker #(
    parameter int POS_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  ps2mt_pkg::cfg_index_t       cfg_index,
    input  logic                        cfg_wdata,
    // received bytes
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [POS_WIDTH-1:0]        m_x_position,
    output logic [POS_WIDTH-1:0]        m_y_position,
    output logic signed [POS_WIDTH-1:0] m_z_position,
    output logic [ps2mt_pkg::BUTTON_W-1:0] m_button_bits
);
    import ps2mt_pkg::*;

    logic          four_byte_packets_reg;
    logic          wheel_enabled_reg;
    logic          pkt_valid;
    logic          pkt_ready;
    ps2mt_packet_t pkt;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_byte_packets_reg <= 1'b0;
            wheel_enabled_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FOUR_BYTE_PACKETS: four_byte_packets_reg <= cfg_wdata;
                CFG_WHEEL_ENABLED:     wheel_enabled_reg     <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    ps2mt_assembler u_assembler (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .four_byte_packets (four_byte_packets_reg),
        .wheel_enabled     (wheel_enabled_reg),
        .pkt_valid         (pkt_valid),
        .pkt_ready         (pkt_ready),
        .pkt               (pkt)
    );

    ps2mt_accumulator #(
        .POS_WIDTH (POS_WIDTH)
    ) u_accumulator (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pkt_valid     (pkt_valid),
        .pkt_ready     (pkt_ready),
        .pkt           (pkt),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_position  (m_x_position),
        .m_y_position  (m_y_position),
        .m_z_position  (m_z_position),
        .m_button_bits (m_button_bits)
    );

endmodule
